[src/owtc_pkg.sv]
// ----------------------------------------------------------------------------
// owtc_pkg: shared types and constants of the one-wire thermometer controller
// Holds the command bytes, presence masks, register indexes and the
// temperature word type used by the core and its scaling unit.
// ----------------------------------------------------------------------------
package owtc_pkg;

    localparam int TEMP_W = 16;

    typedef logic signed [TEMP_W-1:0] temp_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CONV_TICKS    = 3'd0,
        REG_RESET_PATTERN = 3'd1,
        REG_CLAMP_LOW     = 3'd2,
        REG_CLAMP_HIGH    = 3'd3,
        REG_FAIL_CODE     = 3'd4
    } reg_index_t;

    // Bus commands
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
    localparam logic [7:0] CMD_READ_SLOT = 8'hFF;
    localparam logic [7:0] SLOT_ONE      = 8'hFF;
    localparam logic [7:0] SLOT_ZERO     = 8'h00;

    // Presence check on the reset echo
    localparam logic [7:0] PRES_BUSY_MASK = 8'h70;
    localparam logic [7:0] PRES_HIGH_MASK = 8'h80;

    localparam logic [2:0] START_LEN = 3'd3;
    localparam logic [2:0] READ_LEN  = 3'd5;
    localparam logic [2:0] LOW_BYTE_ACTION = 3'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] CONV_TICKS_RST    = 16'd800;
    localparam logic [7:0]  RESET_PATTERN_RST = 8'd240;
    localparam temp_t       CLAMP_LOW_RST     = -16'sd550;
    localparam temp_t       CLAMP_HIGH_RST    = 16'sd1250;
    localparam temp_t       FAIL_CODE_RST     = 16'sh8000;

    // Command byte of an action; out-of-range actions fall back to entry zero
    function automatic logic [7:0] cmd_byte(input logic is_start, input logic [2:0] idx);
        logic [7:0] data;
        data = 8'h00;
        if (is_start)
        begin
            case (idx)
                3'd1:    data = CMD_SKIP_ROM;
                3'd2:    data = CMD_CONVERT;
                default: data = 8'h00;
            endcase
        end
        else
        begin
            case (idx)
                3'd1:    data = CMD_SKIP_ROM;
                3'd2:    data = CMD_READ_PAD;
                3'd3:    data = CMD_READ_SLOT;
                3'd4:    data = CMD_READ_SLOT;
                default: data = 8'h00;
            endcase
        end
        return data;
    endfunction

endpackage

[src/owtc_temp_scale.sv]
// ----------------------------------------------------------------------------
// owtc_temp_scale: raw sensor word to tenths of degree
// Computes raw*10/16 truncated toward zero, raises it to the lower bound
// and then lowers it to the upper bound.
// ----------------------------------------------------------------------------
module owtc_temp_scale
(
    input  logic [15:0]     raw,
    input  owtc_pkg::temp_t clamp_low,
    input  owtc_pkg::temp_t clamp_high,
    output owtc_pkg::temp_t temp_out
);

    logic signed [19:0] raw_ext;
    logic signed [19:0] times_ten;
    logic signed [19:0] biased;
    logic signed [19:0] quot;
    owtc_pkg::temp_t    scaled;
    owtc_pkg::temp_t    raised;

    // Multiply by ten as two shifted adds
    assign raw_ext   = 20'(signed'(raw));
    assign times_ten = (raw_ext <<< 3) + (raw_ext <<< 1);

    // Divide by sixteen, rounding toward zero
    assign biased = times_ten + (times_ten[19] ? 20'sd15 : 20'sd0);
    assign quot   = biased >>> 4;
    assign scaled = owtc_pkg::temp_t'(quot[15:0]);

    // Clamp low first, then high
    assign raised   = (scaled < clamp_low) ? clamp_low : scaled;
    assign temp_out = (raised > clamp_high) ? clamp_high : raised;

endmodule

[src/onewire_thermometer_controller_core.sv]
// ----------------------------------------------------------------------------
// onewire_thermometer_controller_core: 1-Wire thermometer master over UART
// Runs the start sequence (reset, skip ROM, convert), waits a set number of
// millisecond ticks, runs the read sequence and reports the temperature.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, operation, rx_byte    | into core
//  output  | out_valid, out_ready, tx_send, tx_byte,   | out of core
//          | slow_baud, temp_update, temperature,      |
//          | meas_fail                                 |
//  config  | cfg_write, cfg_index, cfg_data            | into core
//
// Each transaction gives exactly one result transaction, registered first in
// the input register and then in the result register; one transaction a cycle
// is sustained while the output side is free, bounded by the single sequencer step.
// Reset loads the register defaults and parks the sequencer in start pending.
// A held output stalls the input register, which still takes one transaction.
//
module onewire_thermometer_controller_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [7:0]            rx_byte,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  tx_send,
    output logic [7:0]            tx_byte,
    output logic                  slow_baud,
    output logic                  temp_update,
    output owtc_pkg::temp_t       temperature,
    output logic                  meas_fail,
    // configuration
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    typedef enum logic [1:0] {
        PH_PENDING = 2'd0,
        PH_START   = 2'd1,
        PH_WAIT    = 2'd2,
        PH_READ    = 2'd3
    } phase_t;

    // Configuration registers
    logic [15:0]     conv_ticks_reg;
    logic [7:0]      reset_pattern_reg;
    owtc_pkg::temp_t clamp_low_reg;
    owtc_pkg::temp_t clamp_high_reg;
    owtc_pkg::temp_t fail_code_reg;

    // Input register
    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] rx_reg;

    // Sequencer state
    phase_t      phase_reg,        phase_next;
    logic [2:0]  action_reg,       action_next;
    logic [3:0]  bit_count_reg,    bit_count_next;
    logic [7:0]  read_shift_reg,   read_shift_next;
    logic [7:0]  write_shift_reg,  write_shift_next;
    logic [7:0]  low_byte_reg,     low_byte_next;
    logic        start_failed_reg, start_failed_next;
    logic [15:0] wait_count_reg,   wait_count_next;

    // Result register
    logic            out_valid_reg;
    logic            tx_send_reg,     tx_send_next;
    logic [7:0]      tx_byte_reg,     tx_byte_next;
    logic            slow_baud_reg,   slow_baud_next;
    logic            temp_update_reg, temp_update_next;
    owtc_pkg::temp_t temperature_reg, temperature_next;
    logic            meas_fail_reg,   meas_fail_next;

    logic            advance;
    owtc_pkg::temp_t scaled_temp;

    // Handshake: the input register drains whenever the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Scale the high byte as it completes with the stored low byte
    owtc_temp_scale u_scale
    (
        .raw        ({rx_reg[1], read_shift_reg[7:1], low_byte_reg}),
        .clamp_low  (clamp_low_reg),
        .clamp_high (clamp_high_reg),
        .temp_out   (scaled_temp)
    );

    // Sequencer step for the transaction in the input register
    always_comb
    begin
        logic       seq_end;
        logic       seq_err;
        logic       ok;
        logic [2:0] len;
        logic [2:0] idx;
        logic [7:0] data;
        logic [3:0] bits_inc;

        phase_next        = phase_reg;
        action_next       = action_reg;
        bit_count_next    = bit_count_reg;
        read_shift_next   = read_shift_reg;
        write_shift_next  = write_shift_reg;
        low_byte_next     = low_byte_reg;
        start_failed_next = start_failed_reg;
        wait_count_next   = wait_count_reg;
        tx_send_next      = 1'b0;
        tx_byte_next      = 8'h00;
        slow_baud_next    = 1'b0;
        temp_update_next  = 1'b0;
        temperature_next  = '0;
        meas_fail_next    = 1'b0;

        seq_end  = 1'b0;
        seq_err  = 1'b0;
        ok       = 1'b0;
        len      = (phase_reg == PH_START) ? owtc_pkg::START_LEN : owtc_pkg::READ_LEN;
        idx      = action_reg;
        data     = 8'h00;
        bits_inc = bit_count_reg + 4'd1;

        case (phase_reg)
            PH_PENDING:
            begin
                // first tick opens the start sequence with a reset pulse
                if (!op_reg)
                begin
                    phase_next     = PH_START;
                    action_next    = 3'd0;
                    tx_send_next   = 1'b1;
                    slow_baud_next = 1'b1;
                    tx_byte_next   = reset_pattern_reg;
                end
            end
            PH_WAIT:
            begin
                if (!op_reg)
                begin
                    if (wait_count_reg <= 16'd1)
                    begin
                        wait_count_next = 16'd0;
                        phase_next      = PH_READ;
                        action_next     = 3'd0;
                        tx_send_next    = 1'b1;
                        slow_baud_next  = 1'b1;
                        tx_byte_next    = reset_pattern_reg;
                    end
                    else
                    begin
                        wait_count_next = wait_count_reg - 16'd1;
                    end
                end
            end
            PH_START, PH_READ:
            begin
                if (op_reg)
                begin
                    if (action_reg == 3'd0)
                    begin
                        // presence check on the reset echo
                        read_shift_next = rx_reg;
                        ok = ((rx_reg & owtc_pkg::PRES_BUSY_MASK) != owtc_pkg::PRES_BUSY_MASK)
                          && ((rx_reg & owtc_pkg::PRES_HIGH_MASK) == owtc_pkg::PRES_HIGH_MASK);
                        if (!ok)
                        begin
                            seq_end = 1'b1;
                            seq_err = 1'b1;
                        end
                        else
                        begin
                            idx = action_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        // shift in the echoed bit, LSB first
                        read_shift_next = {rx_reg[1], read_shift_reg[7:1]};
                        bit_count_next  = bits_inc;
                        if (bits_inc < 4'd8)
                        begin
                            write_shift_next = {1'b0, write_shift_reg[7:1]};
                            tx_send_next     = 1'b1;
                            tx_byte_next     = write_shift_reg[1] ? owtc_pkg::SLOT_ONE
                                                                  : owtc_pkg::SLOT_ZERO;
                        end
                        else
                        begin
                            ok = 1'b1;
                            if (phase_reg == PH_READ && action_reg == owtc_pkg::LOW_BYTE_ACTION)
                                low_byte_next = read_shift_next;
                            idx = action_reg + 3'd1;
                        end
                    end

                    // advance to the next action or close the sequence
                    if (ok)
                    begin
                        action_next = idx;
                        if (idx >= len)
                        begin
                            seq_end = 1'b1;
                        end
                        else
                        begin
                            data             = owtc_pkg::cmd_byte(phase_reg == PH_START, idx);
                            write_shift_next = data;
                            bit_count_next   = 4'd0;
                            tx_send_next     = 1'b1;
                            tx_byte_next     = data[0] ? owtc_pkg::SLOT_ONE
                                                       : owtc_pkg::SLOT_ZERO;
                        end
                    end

                    if (seq_end)
                    begin
                        if (phase_reg == PH_START)
                        begin
                            start_failed_next = seq_err;
                            phase_next        = PH_WAIT;
                            wait_count_next   = conv_ticks_reg;
                        end
                        else
                        begin
                            // report and restart the start sequence at once
                            temp_update_next = 1'b1;
                            if (seq_err || start_failed_reg)
                            begin
                                meas_fail_next   = 1'b1;
                                temperature_next = fail_code_reg;
                            end
                            else
                            begin
                                temperature_next = scaled_temp;
                            end
                            phase_next     = PH_START;
                            action_next    = 3'd0;
                            tx_send_next   = 1'b1;
                            slow_baud_next = 1'b1;
                            tx_byte_next   = reset_pattern_reg;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_PENDING;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_ticks_reg    <= owtc_pkg::CONV_TICKS_RST;
            reset_pattern_reg <= owtc_pkg::RESET_PATTERN_RST;
            clamp_low_reg     <= owtc_pkg::CLAMP_LOW_RST;
            clamp_high_reg    <= owtc_pkg::CLAMP_HIGH_RST;
            fail_code_reg     <= owtc_pkg::FAIL_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (owtc_pkg::reg_index_t'(cfg_index))
                owtc_pkg::REG_CONV_TICKS:    conv_ticks_reg    <= cfg_data;
                owtc_pkg::REG_RESET_PATTERN: reset_pattern_reg <= cfg_data[7:0];
                owtc_pkg::REG_CLAMP_LOW:     clamp_low_reg     <= owtc_pkg::temp_t'(cfg_data);
                owtc_pkg::REG_CLAMP_HIGH:    clamp_high_reg    <= owtc_pkg::temp_t'(cfg_data);
                owtc_pkg::REG_FAIL_CODE:     fail_code_reg     <= owtc_pkg::temp_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // Input register: capture a transaction whenever there is room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= operation;
            rx_reg <= rx_byte;
        end
    end

    // Sequencer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PENDING;
            action_reg       <= 3'd0;
            bit_count_reg    <= 4'd0;
            read_shift_reg   <= 8'h00;
            write_shift_reg  <= 8'h00;
            low_byte_reg     <= 8'h00;
            start_failed_reg <= 1'b0;
            wait_count_reg   <= 16'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg        <= phase_next;
                action_reg       <= action_next;
                bit_count_reg    <= bit_count_next;
                read_shift_reg   <= read_shift_next;
                write_shift_reg  <= write_shift_next;
                low_byte_reg     <= low_byte_next;
                start_failed_reg <= start_failed_next;
                wait_count_reg   <= wait_count_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load only with a new result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_send_reg     <= tx_send_next;
            tx_byte_reg     <= tx_byte_next;
            slow_baud_reg   <= slow_baud_next;
            temp_update_reg <= temp_update_next;
            temperature_reg <= temperature_next;
            meas_fail_reg   <= meas_fail_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tx_send     = tx_send_reg;
    assign tx_byte     = tx_byte_reg;
    assign slow_baud   = slow_baud_reg;
    assign temp_update = temp_update_reg;
    assign temperature = temperature_reg;
    assign meas_fail   = meas_fail_reg;

    // A quiet result carries no byte and no baud switch
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_send) |-> (tx_byte == 8'h00 && !slow_baud))
        else $error("idle result carries transmit payload");

    // A failure is only flagged with a reported temperature
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && meas_fail) |-> temp_update)
        else $error("fail flag without temperature update");

    // Every report starts the next measurement with a reset pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && temp_update) |-> (tx_send && slow_baud))
        else $error("report without restart reset pulse");

    // An empty output side never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output");

endmodule
